@@ hw/rtl/mqm_pkg.sv @@
// Package for the multi-queue mailbox: item structs, field widths and status codes.
// Used by multi_queue_mailbox_core and its testbench; depends on nothing else.
package mqm_pkg;

	// Fixed field widths of the request and response items
	localparam int QID_W     = 3;
	localparam int PAYLOAD_W = 64;
	localparam int STATUS_W  = 2;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	// Operation codes
	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_RECV = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [QID_W-1:0]     queue_id;
		logic [PAYLOAD_W-1:0] message_payload;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [PAYLOAD_W-1:0] received_payload;
		logic                 received_valid;
	} rsp_item_t;

endpackage

@@ hw/rtl/multi_queue_mailbox_core.sv @@
// Results: an accepted item passes through stage 1 and then the response register.
// Throughput: one item per cycle unless the response channel stalls; an OK item
// does one memory write or read and one read-modify-write of its queue pointers.
// Reset: arst_n clears head, tail and fill count of every queue and the pipeline
// valids at once; the message memory is not cleared and needs no clearing pass.
module multi_queue_mailbox_core #(
	parameter int NUM_QUEUES    = 8,
	parameter int QUEUE_DEPTH   = 8,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  mqm_pkg::req_item_t req_item,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mqm_pkg::rsp_item_t rsp_item
);
	import mqm_pkg::*;

	// Only ids below 2**QID_W can ever be named
	localparam int NQ        = (NUM_QUEUES < (1 << QID_W)) ? NUM_QUEUES : (1 << QID_W);
	localparam int QW        = $clog2(NQ);
	localparam int SW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int AW        = QW + SW;
	localparam int MEM_DEPTH = 1 << AW;

	// Queue pointer registers
	logic [SW-1:0] head_q [NQ];
	logic [SW-1:0] tail_q [NQ];
	logic [CW-1:0] cnt_q  [NQ];

	// Message memory
	logic [PAYLOAD_WIDTH-1:0] msg_mem [MEM_DEPTH];

	// Stage 1 and response registers
	logic                     vld_s1;
	logic [STATUS_W-1:0]      status_s1;
	logic                     rd_s1;
	logic [PAYLOAD_WIDTH-1:0] rdata_s1;
	logic                     rsp_valid_q;
	rsp_item_t                rsp_item_q;

	logic                accept;
	logic                s1_adv;
	logic [QW-1:0]       q_idx;
	logic                qid_ok;
	logic                is_send;
	logic [SW-1:0]       head_rd;
	logic [SW-1:0]       tail_rd;
	logic [CW-1:0]       cnt_rd;
	logic                q_full;
	logic                q_empty;
	logic [STATUS_W-1:0] status_new;
	logic                do_wr;
	logic                do_rd;
	logic [SW-1:0]       head_nxt;
	logic [SW-1:0]       tail_nxt;

	// Handshake: stage 1 moves on when the response register is free or taken
	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = vld_s1 && !s1_adv;
	assign accept    = req_valid && !req_stall;

	// Decode the item and look up its queue
	assign q_idx   = req_item.queue_id[QW-1:0];
	assign qid_ok  = (req_item.queue_id != '0) && (int'(req_item.queue_id) < NUM_QUEUES);
	assign is_send = (req_item.kind == KIND_SEND);

	always_comb begin
		head_rd = '0;
		tail_rd = '0;
		cnt_rd  = '0;
		if (qid_ok) begin
			head_rd = head_q[q_idx];
			tail_rd = tail_q[q_idx];
			cnt_rd  = cnt_q[q_idx];
		end
	end

	assign q_full  = (cnt_rd == CW'(QUEUE_DEPTH));
	assign q_empty = (cnt_rd == '0);

	// Pick the status; the id check wins over full and empty
	always_comb begin
		priority if (!qid_ok) begin
			status_new = ST_BAD_ID;
		end else if (is_send && q_full) begin
			status_new = ST_FULL;
		end else if (!is_send && q_empty) begin
			status_new = ST_EMPTY;
		end else begin
			status_new = ST_OK;
		end
	end

	assign do_wr = accept && (status_new == ST_OK) && is_send;
	assign do_rd = accept && (status_new == ST_OK) && !is_send;

	// Wrap the ring pointers
	assign head_nxt = (head_rd == SW'(QUEUE_DEPTH - 1)) ? '0 : head_rd + 1'b1;
	assign tail_nxt = (tail_rd == SW'(QUEUE_DEPTH - 1)) ? '0 : tail_rd + 1'b1;

	// Update the pointers of the addressed queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (do_wr) begin
				tail_q[q_idx] <= tail_nxt;
				cnt_q[q_idx]  <= cnt_rd + 1'b1;
			end
			if (do_rd) begin
				head_q[q_idx] <= head_nxt;
				cnt_q[q_idx]  <= cnt_rd - 1'b1;
			end
		end
	end

	// Write at the tail, read at the head; read data holds until the next read
	always_ff @(posedge clk) begin
		if (do_wr) begin
			msg_mem[{q_idx, tail_rd}] <= req_item.message_payload[PAYLOAD_WIDTH-1:0];
		end
		if (do_rd) begin
			rdata_s1 <= msg_mem[{q_idx, head_rd}];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			status_s1 <= ST_OK;
			rd_s1     <= 1'b0;
		end else if (!req_stall) begin
			vld_s1    <= accept;
			status_s1 <= status_new;
			rd_s1     <= do_rd;
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= vld_s1;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (s1_adv && vld_s1) begin
			rsp_item_q.status           <= status_s1;
			rsp_item_q.received_valid   <= rd_s1;
			rsp_item_q.received_payload <= rd_s1 ? PAYLOAD_W'(rdata_s1) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

`ifndef SYNTH
	// A delivered message always carries the success status
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.received_valid |-> rsp_item.status == ST_OK)
		else $error("received message without success status");

	// A queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && qid_ok |-> cnt_rd <= CW'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	// Read data waiting in stage 1 is not overwritten while it is held
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && rd_s1 && !s1_adv |=> $stable(rdata_s1))
		else $error("held read data changed");

	// A write and a read never happen for the same item
	assert property (@(posedge clk) disable iff (!arst_n)
		!(do_wr && do_rd))
		else $error("write and read issued together");
`endif

endmodule

@@ dv/tb_multi_queue_mailbox_core.sv @@
// Testbench for multi_queue_mailbox_core: directed table, then random send/receive traffic
// with random request gaps and response stalls, checked against a behavioral mailbox predictor.
// Depends on mqm_pkg and the multi_queue_mailbox_core RTL.
module tb_multi_queue_mailbox_core;
	import mqm_pkg::*;

	localparam int NQ             = 8;
	localparam int DEPTH          = 8;
	localparam int RAND_ITEMS     = 1300;
	localparam int CHUNK          = 50;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 6;
	localparam logic [QID_W-1:0] QID_NONE = '0;

	typedef struct {
		req_item_t req;
		bit        typed;
		rsp_item_t rsp;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req_item;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp_item;

	// Predictor state: one ring per queue
	logic [PAYLOAD_W-1:0] q_slots [NQ][DEPTH];
	int                   q_head  [NQ];
	int                   q_tail  [NQ];
	int                   q_fill  [NQ];

	rsp_item_t pending_answers[$];
	dir_row_t  dir_table[$];
	rsp_item_t answer;
	rsp_item_t oldest;
	bit        cur_typed;
	rsp_item_t cur_typed_rsp;
	bit        no_idle;
	int        errors;
	int        idle_cycles;
	int        n_items;
	int        n_stored;
	int        n_delivered;
	int        n_full;
	int        n_empty;
	int        n_bad_id;

	multi_queue_mailbox_core #(
		.NUM_QUEUES(NQ),
		.QUEUE_DEPTH(DEPTH),
		.PAYLOAD_WIDTH(PAYLOAD_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Compute the answer to one request and advance the predicted queues
	function automatic rsp_item_t mailbox_answer(input req_item_t r);
		rsp_item_t o;
		int        q;
		o = '0;
		o.status = ST_OK;
		q = int'(r.queue_id);
		if (r.queue_id == QID_NONE || q >= NQ) begin
			o.status = ST_BAD_ID;
		end else if (r.kind == KIND_SEND) begin
			if (q_fill[q] >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				q_slots[q][q_tail[q]] = r.message_payload;
				q_tail[q] = (q_tail[q] + 1) % DEPTH;
				q_fill[q] = q_fill[q] + 1;
			end
		end else begin
			if (q_fill[q] == 0) begin
				o.status = ST_EMPTY;
			end else begin
				o.received_payload = q_slots[q][q_head[q]];
				o.received_valid = 1'b1;
				q_head[q] = (q_head[q] + 1) % DEPTH;
				q_fill[q] = q_fill[q] - 1;
			end
		end
		return o;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic add_row(input logic kind, input logic [QID_W-1:0] qid,
			input logic [PAYLOAD_W-1:0] payload, input bit typed,
			input logic [STATUS_W-1:0] st, input logic [PAYLOAD_W-1:0] got,
			input logic got_valid);
		dir_row_t row;
		row.req.kind = kind;
		row.req.queue_id = qid;
		row.req.message_payload = payload;
		row.typed = typed;
		row.rsp.status = st;
		row.rsp.received_payload = got;
		row.rsp.received_valid = got_valid;
		dir_table.push_back(row);
	endtask

	// Offer one item after a random gap and hold it until accepted
	task automatic drive_item(input req_item_t it, input bit typed, input rsp_item_t rsp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_item = it;
		cur_typed = typed;
		cur_typed_rsp = rsp;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string field, input logic [PAYLOAD_W-1:0] exp_v,
			input logic [PAYLOAD_W-1:0] act_v);
		errors++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
	endtask

	// Predict on each accepted request, check each accepted response
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				answer = mailbox_answer(req_item);
				if (cur_typed)
					answer = cur_typed_rsp;
				pending_answers.push_back(answer);
				n_items++;
				case (answer.status)
					ST_OK: begin
						if (answer.received_valid)
							n_delivered++;
						else
							n_stored++;
					end
					ST_FULL: n_full++;
					ST_EMPTY: n_empty++;
					default: n_bad_id++;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_answers.size() == 0) begin
					errors++;
					$display("%0t: response with nothing pending, actual %h", $time, rsp_item);
				end else begin
					oldest = pending_answers.pop_front();
					if (rsp_item.status !== oldest.status)
						report_mismatch("status", oldest.status, rsp_item.status);
					if (rsp_item.received_payload !== oldest.received_payload)
						report_mismatch("received_payload", oldest.received_payload,
							rsp_item.received_payload);
					if (rsp_item.received_valid !== oldest.received_valid)
						report_mismatch("received_valid", oldest.received_valid,
							rsp_item.received_valid);
				end
			end
		end
	end

	// Stop the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d responses pending", $time,
					pending_answers.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stall the response channel in random bursts
	initial begin
		int r;
		int len;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (no_idle) begin
				rsp_stall = 1'b0;
				len = 1;
			end else if (r < 40) begin
				rsp_stall = 1'b0;
				len = $urandom_range(1, 30);
			end else if (r < 90) begin
				rsp_stall = 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				rsp_stall = 1'b1;
				len = $urandom_range(10, 40);
			end
			repeat (len - 1) @(negedge clk);
		end
	end

	// Reset, directed table, random traffic, drain and verdict
	initial begin
		req_item_t it;
		rsp_item_t none;
		int        send_pct;
		int        hot;
		int        r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		cur_typed = 1'b0;
		cur_typed_rsp = '0;
		no_idle = 1'b0;
		none = '0;
		errors = 0;
		idle_cycles = 0;
		n_items = 0;
		n_stored = 0;
		n_delivered = 0;
		n_full = 0;
		n_empty = 0;
		n_bad_id = 0;
		for (int q = 0; q < NQ; q++) begin
			q_head[q] = 0;
			q_tail[q] = 0;
			q_fill[q] = 0;
			for (int s = 0; s < DEPTH; s++)
				q_slots[q][s] = '0;
		end

		// Empty after reset, reserved id both ways, payload extremes, fill to full, drain
		add_row(KIND_RECV, 3'd1, '0, 1'b1, ST_EMPTY, '0, 1'b0);
		add_row(KIND_SEND, QID_NONE, '1, 1'b1, ST_BAD_ID, '0, 1'b0);
		add_row(KIND_RECV, QID_NONE, '1, 1'b1, ST_BAD_ID, '0, 1'b0);
		add_row(KIND_SEND, 3'd7, '1, 1'b1, ST_OK, '0, 1'b0);
		add_row(KIND_RECV, 3'd7, '0, 1'b1, ST_OK, '1, 1'b1);
		add_row(KIND_SEND, 3'd1, '0, 1'b1, ST_OK, '0, 1'b0);
		add_row(KIND_RECV, 3'd1, '1, 1'b1, ST_OK, '0, 1'b1);
		for (int k = 0; k < DEPTH; k++)
			add_row(KIND_SEND, 3'd3, 64'h0101_0101_0101_0101 * (k + 1), 1'b0,
				ST_OK, '0, 1'b0);
		add_row(KIND_SEND, 3'd3, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, ST_FULL, '0, 1'b0);
		for (int k = 0; k < DEPTH; k++)
			add_row(KIND_RECV, 3'd3, '0, 1'b0, ST_OK, '0, 1'b0);
		add_row(KIND_RECV, 3'd3, '0, 1'b1, ST_EMPTY, '0, 1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i])
			drive_item(dir_table[i].req, dir_table[i].typed, dir_table[i].rsp);

		// Random traffic in chunks that lean toward filling or draining one hot queue, or stay balanced
		send_pct = 50;
		hot = 1;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % CHUNK == 0) begin
				r = $urandom_range(0, 3);
				send_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
				hot = $urandom_range(1, NQ - 1);
				no_idle = ($urandom_range(0, 4) == 0);
			end
			if (i == RAND_ITEMS / 2) begin
				// Hold off until every pending response is back
				req_valid = 1'b0;
				while (pending_answers.size() != 0)
					@(negedge clk);
			end
			it.kind = ($urandom_range(0, 99) < send_pct) ? KIND_SEND : KIND_RECV;
			r = $urandom_range(0, 99);
			if (r < 5)
				it.queue_id = QID_NONE;
			else if (r < 65)
				it.queue_id = QID_W'(hot);
			else
				it.queue_id = QID_W'($urandom_range(1, NQ - 1));
			r = $urandom_range(0, 99);
			if (r < 5)
				it.message_payload = '0;
			else if (r < 10)
				it.message_payload = '1;
			else
				it.message_payload = {$urandom, $urandom};
			drive_item(it, 1'b0, none);
		end
		req_valid = 1'b0;
		no_idle = 1'b0;

		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_answers.size() != 0) begin
			errors++;
			$display("%0t: %0d responses never arrived", $time, pending_answers.size());
		end

		$display("Ran %0d requests: %0d stored, %0d delivered, %0d rejected full,",
			n_items, n_stored, n_delivered, n_full);
		$display("%0d reported empty, %0d with a bad queue id; %0d mismatches",
			n_empty, n_bad_id, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mqm_pkg.sv
hw/rtl/multi_queue_mailbox_core.sv
dv/tb_multi_queue_mailbox_core.sv
